### src/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, constants and helper functions of the range extreme engine.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned BlockSize   = 16;
  localparam int unsigned MaxElements = 1024;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned Levels      = 7;
  localparam int unsigned NumBlocks   = MaxElements / BlockSize;
  localparam int unsigned SparseDepth = Levels * NumBlocks;

  // request codes on the input channel
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // configuration register indexes
  localparam logic CFG_ORDER  = 1'b0;
  localparam logic CFG_SIGNED = 1'b1;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_QUERY,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] value;
    logic [9:0]  left;
    logic [10:0] right_excl;
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_LVL_A,
    S_LVL_B,
    S_LVL_C,
    S_Q0,
    S_Q1,
    S_Q2,
    S_Q3,
    S_OUT
  } state_e;

  // strict compare, ties go to the second operand
  function automatic logic beats(logic [31:0] a, logic [31:0] b, logic order_max,
                                 logic sgn);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a ^ {sgn, 31'b0};
    kb = b ^ {sgn, 31'b0};
    return order_max ? (ka > kb) : (ka < kb);
  endfunction

  // count trailing zeros, zero mask gives 0
  function automatic logic [3:0] tz16(logic [15:0] m);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) n = 4'(i);
    end
    return n;
  endfunction

  // index of highest set bit, 0 for 0 or 1
  function automatic logic [2:0] top_bit6(logic [5:0] x);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (x[i]) n = 3'(i);
    end
    return n;
  endfunction

endpackage

### src/rmq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Accepts request beats, decodes the request type and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    req_type_i,
  input  logic [31:0]   value_i,
  input  logic [9:0]    left_i,
  input  logic [10:0]   right_excl_i,
  output logic          q_valid_o,
  output rmq_pkg::req_t q_item_o,
  input  logic          q_pop_i
);

  rmq_pkg::req_t slot_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;
  logic          push;
  rmq_pkg::req_t item;

  // decode request type
  always_comb begin
    item.value      = value_i;
    item.left       = left_i;
    item.right_excl = right_excl_i;
    unique case (req_type_i)
      rmq_pkg::REQ_APPEND: item.op = rmq_pkg::OP_APPEND;
      rmq_pkg::REQ_QUERY:  item.op = rmq_pkg::OP_QUERY;
      rmq_pkg::REQ_CLEAR:  item.op = rmq_pkg::OP_CLEAR;
      default:             item.op = rmq_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rptr_q];

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (q_pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wptr_q] <= item;
  end

endmodule

### src/rmq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_back
// Executes appends, queries and clears against the value, mask and sparse
// stores, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module rmq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          order_mode_i,
  input  logic          signed_mode_i,
  input  logic          q_valid_i,
  input  rmq_pkg::req_t q_item_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [9:0]    best_index_o,
  output logic [1:0]    status_o
);

  rmq_pkg::state_e state_q, state_d;
  rmq_pkg::req_t   cur_q;

  logic [10:0] count_q;
  logic [4:0]  hgt_q;
  logic [3:0]  stk_q   [16];
  logic [31:0] bval_q  [16];
  logic [15:0] bmask_q [16];
  logic [2:0]  lvl_q;
  logic [6:0]  nb_q;
  logic [9:0]  ia_q, ib_q, ic_q, id_q, xi_q;
  logic [31:0] xv_q;
  logic [9:0]  res_idx_q;
  logic [1:0]  res_st_q;
  logic        out_valid_q;
  logic [9:0]  out_idx_q;
  logic [1:0]  out_st_q;

  // storage
  logic [31:0] vmem [rmq_pkg::MaxElements];
  logic [15:0] mmem [rmq_pkg::MaxElements];
  logic [9:0]  smem [rmq_pkg::SparseDepth];

  logic [9:0]  va0, va1, ma0, ma1;
  logic [8:0]  sa0, sa1, swaddr;
  logic [9:0]  swdata;
  logic        mem_we, swe;
  logic [31:0] vrd0_q, vrd1_q;
  logic [15:0] mrd0_q, mrd1_q;
  logic [9:0]  srd0_q, srd1_q;

  // append helpers
  logic [9:0]  pos;
  logic [3:0]  off;
  logic [3:0]  tix;
  logic [3:0]  top_off;
  logic        do_pop;
  logic [15:0] newmask;
  logic [3:0]  first_off;

  // sparse build helpers
  logic [7:0]  pw, hh, kk, kh;
  logic [3:0]  nl;
  logic        lvl_more;
  logic        lvl_win;

  // query helpers
  logic [9:0]  lq;
  logic [10:0] rm1;
  logic [9:0]  rq;
  logic [6:0]  lb;
  logic [5:0]  rb;
  logic        lb_le, lb_lt;
  logic [5:0]  blk_span;
  logic [2:0]  pp;
  logic [5:0]  cblk;
  logic [15:0] low;
  logic [9:0]  qa, qd, qs;
  logic        bad_query;
  logic        cd_win, xy_win, ab_win;
  logic [9:0]  yi;
  logic [31:0] yv;
  logic        out_free;

  assign pos     = count_q[9:0];
  assign off     = pos[3:0];
  assign tix     = hgt_q[3:0] - 4'd1;
  assign top_off = stk_q[tix];
  assign do_pop  = (hgt_q != 5'd0) &&
                   !rmq_pkg::beats(bval_q[top_off], cur_q.value, order_mode_i, signed_mode_i);
  assign newmask = ((hgt_q != 5'd0) ? bmask_q[top_off] : 16'h0) | (16'h1 << off);
  assign first_off = (hgt_q == 5'd0) ? off : stk_q[0];

  assign pw       = 8'd1 << lvl_q;
  assign hh       = 8'd1 << (lvl_q - 3'd1);
  assign kk       = {1'b0, nb_q} - pw;
  assign kh       = kk + hh;
  assign nl       = {1'b0, lvl_q} + 4'd1;
  assign lvl_more = (nl < 4'(rmq_pkg::Levels)) && ((9'd1 << nl) <= {2'b0, nb_q});
  assign lvl_win  = rmq_pkg::beats(vrd0_q, vrd1_q, order_mode_i, signed_mode_i);

  assign lq        = cur_q.left;
  assign rm1       = cur_q.right_excl - 11'd1;
  assign rq        = rm1[9:0];
  assign lb        = {1'b0, lq[9:4]} + 7'd1;
  assign rb        = rq[9:4];
  assign lb_le     = lb <= {1'b0, rb};
  assign lb_lt     = lb < {1'b0, rb};
  assign blk_span  = rb - lb[5:0];
  assign pp        = rmq_pkg::top_bit6(blk_span);
  assign cblk      = rb - (6'd1 << pp);
  assign low       = 16'hFFFF << lq[3:0];
  assign qa        = {lq[9:4], rmq_pkg::tz16(mrd0_q & low)};
  assign qd        = {rb, rmq_pkg::tz16(mrd1_q)};
  assign qs        = {rb, rmq_pkg::tz16(mrd1_q & low)};
  assign bad_query = (cur_q.right_excl <= {1'b0, lq}) || (cur_q.right_excl > count_q);
  assign ab_win    = rmq_pkg::beats(vrd0_q, vrd1_q, order_mode_i, signed_mode_i);
  assign cd_win    = ab_win;
  assign yi        = cd_win ? ic_q : id_q;
  assign yv        = cd_win ? vrd0_q : vrd1_q;
  assign xy_win    = rmq_pkg::beats(xv_q, yv, order_mode_i, signed_mode_i);

  assign out_free  = !out_valid_q || !out_stall_i;
  assign q_pop_o   = (state_q == rmq_pkg::S_IDLE) && q_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmq_pkg::S_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.op == rmq_pkg::OP_APPEND &&
              count_q != 11'(rmq_pkg::MaxElements)) state_d = rmq_pkg::S_POP;
          else if (q_item_i.op == rmq_pkg::OP_QUERY) state_d = rmq_pkg::S_Q0;
          else state_d = rmq_pkg::S_OUT;
        end
      end
      rmq_pkg::S_POP: begin
        if (!do_pop) begin
          if (off == 4'hF && pos[9:4] != 6'd0) state_d = rmq_pkg::S_LVL_A;
          else state_d = rmq_pkg::S_OUT;
        end
      end
      rmq_pkg::S_LVL_A: state_d = rmq_pkg::S_LVL_B;
      rmq_pkg::S_LVL_B: state_d = rmq_pkg::S_LVL_C;
      rmq_pkg::S_LVL_C: state_d = lvl_more ? rmq_pkg::S_LVL_A : rmq_pkg::S_OUT;
      rmq_pkg::S_Q0: state_d = bad_query ? rmq_pkg::S_OUT : rmq_pkg::S_Q1;
      rmq_pkg::S_Q1: state_d = lb_le ? rmq_pkg::S_Q2 : rmq_pkg::S_OUT;
      rmq_pkg::S_Q2: state_d = lb_lt ? rmq_pkg::S_Q3 : rmq_pkg::S_OUT;
      rmq_pkg::S_Q3: state_d = rmq_pkg::S_OUT;
      rmq_pkg::S_OUT: if (out_free) state_d = rmq_pkg::S_IDLE;
      default: state_d = rmq_pkg::S_IDLE;
    endcase
  end

  // memory addresses and write strobes
  always_comb begin
    va0    = ia_q;
    va1    = ib_q;
    ma0    = rq;
    ma1    = rq;
    sa0    = {lvl_q - 3'd1, kk[5:0]};
    sa1    = {lvl_q - 3'd1, kh[5:0]};
    mem_we = 1'b0;
    swe    = 1'b0;
    swaddr = {3'd0, pos[9:4]};
    swdata = {pos[9:4], first_off};
    unique case (state_q)
      rmq_pkg::S_POP: begin
        mem_we = !do_pop;
        swe    = !do_pop && (off == 4'hF);
      end
      rmq_pkg::S_LVL_B: begin
        va0 = srd0_q;
        va1 = srd1_q;
      end
      rmq_pkg::S_LVL_C: begin
        swe    = 1'b1;
        swaddr = {lvl_q, kk[5:0]};
        swdata = lvl_win ? ia_q : ib_q;
      end
      rmq_pkg::S_Q0: begin
        ma0 = lb_le ? {lq[9:4], 4'hF} : rq;
        sa0 = {pp, lb[5:0]};
        sa1 = {pp, cblk};
      end
      rmq_pkg::S_Q1: begin
        va0 = qa;
        va1 = lb_lt ? srd0_q : qd;
      end
      rmq_pkg::S_Q2: begin
        va0 = ic_q;
        va1 = id_q;
      end
      default: ;
    endcase
  end

  // value, mask and sparse stores
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vmem[pos] <= cur_q.value;
      mmem[pos] <= newmask;
    end
    if (swe) smem[swaddr] <= swdata;
    vrd0_q <= vmem[va0];
    vrd1_q <= vmem[va1];
    mrd0_q <= mmem[ma0];
    mrd1_q <= mmem[ma1];
    srd0_q <= smem[sa0];
    srd1_q <= smem[sa1];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmq_pkg::S_IDLE;
      count_q     <= 11'd0;
      hgt_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // result register load or hand-off
      if (state_q == rmq_pkg::S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        rmq_pkg::S_IDLE: begin
          if (q_valid_i && q_item_i.op == rmq_pkg::OP_CLEAR) begin
            count_q <= 11'd0;
            hgt_q   <= 5'd0;
          end
        end
        rmq_pkg::S_POP: begin
          if (do_pop) hgt_q <= hgt_q - 5'd1;
          else begin
            count_q <= count_q + 11'd1;
            hgt_q   <= (off == 4'hF) ? 5'd0 : hgt_q + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rmq_pkg::S_IDLE: begin
        cur_q     <= q_item_i;
        res_idx_q <= 10'd0;
        res_st_q  <= (q_item_i.op == rmq_pkg::OP_APPEND &&
                      count_q == 11'(rmq_pkg::MaxElements)) ? rmq_pkg::ST_FULL
                                                             : rmq_pkg::ST_OK;
      end
      rmq_pkg::S_POP: begin
        if (!do_pop) begin
          stk_q[hgt_q[3:0]] <= off;
          bval_q[off]       <= cur_q.value;
          bmask_q[off]      <= newmask;
          lvl_q             <= 3'd1;
          nb_q              <= {1'b0, pos[9:4]} + 7'd1;
        end
      end
      rmq_pkg::S_LVL_B: begin
        ia_q <= srd0_q;
        ib_q <= srd1_q;
      end
      rmq_pkg::S_LVL_C: lvl_q <= nl[2:0];
      rmq_pkg::S_Q0: if (bad_query) res_st_q <= rmq_pkg::ST_RANGE;
      rmq_pkg::S_Q1: begin
        if (!lb_le) res_idx_q <= qs;
        ia_q <= qa;
        ib_q <= srd0_q;
        ic_q <= srd1_q;
        id_q <= qd;
      end
      rmq_pkg::S_Q2: begin
        if (lb_lt) begin
          xi_q <= ab_win ? ia_q : ib_q;
          xv_q <= ab_win ? vrd0_q : vrd1_q;
        end else begin
          res_idx_q <= ab_win ? ia_q : id_q;
        end
      end
      rmq_pkg::S_Q3: res_idx_q <= xy_win ? xi_q : yi;
      rmq_pkg::S_OUT: begin
        if (out_free) begin
          out_idx_q <= res_idx_q;
          out_st_q  <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign best_index_o = out_idx_q;
  assign status_o     = out_st_q;

endmodule

### src/range_min_query_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_min_query_engine
// Range extreme index engine: appends values, answers position-of-extreme
// queries over [left, right_excl) from block masks and a sparse table.
// ----------------------------------------------------------------------------
// channel  | signals                                    | direction
// request  | in_valid_i/in_stall_o, req_type, value,    | in
//          | left, right_excl                           |
// result   | out_valid_o/out_stall_i, best_index, status| out
// config   | cfg_we_i, cfg_idx_i, cfg_wdata_i           | in
//
// Query: reads from the two-port stores, then compare.
// Append: one S_POP step per stack pop; a block end after the first builds
// sparse levels, one level per pass through the dual-read sparse store.
// Reset clears counts and control; stores need no clearing.
// A two-beat request queue and a result register decouple the two sides.
// ----------------------------------------------------------------------------
module range_min_query_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] value_i,
  input  logic [9:0]  left_i,
  input  logic [10:0] right_excl_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  best_index_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i
);

  logic          order_mode_q, signed_mode_q;
  logic          q_valid, q_pop;
  rmq_pkg::req_t q_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q  <= 1'b0;
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rmq_pkg::CFG_ORDER) order_mode_q <= cfg_wdata_i;
      if (cfg_idx_i == rmq_pkg::CFG_SIGNED) signed_mode_q <= cfg_wdata_i;
    end
  end

  rmq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .left_i       (left_i),
    .right_excl_i (right_excl_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  rmq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .order_mode_i  (order_mode_q),
    .signed_mode_i (signed_mode_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .best_index_o  (best_index_o),
    .status_o      (status_o)
  );

endmodule
